@@ rtl/approx_bitparallel_matcher_defines.svh @@
// Assertion macros for the approximate bit-parallel matcher checker.
// No dependencies; take it in by include with the bare file name.
`ifndef APPROX_BITPARALLEL_MATCHER_DEFINES_SVH
`define APPROX_BITPARALLEL_MATCHER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define ABPM_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ABPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/abpm_pkg.sv @@
// Shared constants, types and helpers for the approximate bit-parallel matcher.
// No dependencies; used by abpm_step, the top level and the checker.
package abpm_pkg;

    localparam int VEC_W   = 32;           // state vector width
    localparam int MAX_ERR = 4;            // highest error level built
    localparam int LEVELS  = MAX_ERR + 1;
    localparam int REG_W   = 32;           // configuration data width
    localparam int ADDR_W  = 5;            // byte address of five registers
    localparam int POS_W   = 16;
    localparam int LVL_W   = 3;            // width of the reported level
    localparam int CODE_W  = 8;
    localparam int TABLE_DEPTH = 1 << CODE_W;

    // Register indexes (word address)
    localparam logic [2:0] REG_MAX_ERRORS  = 3'd0;
    localparam logic [2:0] REG_MATCH_MASK  = 3'd1;
    localparam logic [2:0] REG_SKIP_MASK   = 3'd2;
    localparam logic [2:0] REG_EXACT_MASK  = 3'd3;
    localparam logic [2:0] REG_SKIP_ENABLE = 3'd4;

    typedef logic [VEC_W-1:0] vec_t;
    typedef vec_t [LEVELS-1:0] vecs_t;

    typedef struct packed {
        logic        skip_enable;
        vec_t        skip_mask;
        vec_t        exact_mask;
        vec_t        match_mask;
        logic [2:0]  max_errors;
    } step_cfg_t;

    typedef struct packed {
        logic             hit;
        logic [LVL_W-1:0] level;
        vecs_t            vectors;
    } step_res_t;

    // Take a 32-bit register or input word into the state vector width.
    function automatic vec_t to_vec(input logic [REG_W-1:0] x);
        vec_t v;
        v = '0;
        for (int i = 0; i < VEC_W; i++)
        begin
            if (i < REG_W)
            begin
                v[i] = x[i % REG_W];
            end
        end
        return v;
    endfunction

endpackage

@@ rtl/abpm_step.sv @@
// One text-byte update of all error levels of the shift-or state.
// Depends on abpm_pkg for vector types and the configuration struct.
module abpm_step (
    input  abpm_pkg::vecs_t     old_vectors,
    input  abpm_pkg::vec_t      char_vector,
    input  abpm_pkg::step_cfg_t cfg,
    output abpm_pkg::step_res_t res
);
    import abpm_pkg::*;

    vec_t              ns [LEVELS];
    vec_t              sor;
    vec_t              err;
    logic [LEVELS-1:0] level_en;
    logic [LEVELS-1:0] hit;

    always_comb
    begin
        // level 0: plain shift-or, then the skip mask when enabled
        sor   = (old_vectors[0] << 1) | char_vector;
        ns[0] = sor;
        if (cfg.skip_enable)
        begin
            ns[0] = ns[0] & (old_vectors[0] | cfg.skip_mask);
        end
        // higher levels: add the error paths from level below
        for (int d = 1; d < LEVELS; d++)
        begin
            sor   = (old_vectors[d] << 1) | char_vector;
            err   = old_vectors[d-1] & ((old_vectors[d-1] & ns[d-1]) << 1);
            ns[d] = (cfg.exact_mask | err) & sor;
            if (cfg.skip_enable)
            begin
                ns[d] = ns[d] & (old_vectors[d] | cfg.skip_mask);
            end
        end
        for (int d = 0; d < LEVELS; d++)
        begin
            level_en[d] = int'(cfg.max_errors) >= d;
            hit[d]      = level_en[d] && ((ns[d] | cfg.match_mask) != '1);
        end
    end

    always_comb
    begin
        res.hit   = 1'b0;
        res.level = '0;
        // lowest matching level wins
        for (int d = LEVELS - 1; d >= 0; d--)
        begin
            if (hit[d])
            begin
                res.hit   = 1'b1;
                res.level = LVL_W'(d);
            end
        end
        for (int d = 0; d < LEVELS; d++)
        begin
            if (res.hit)
            begin
                res.vectors[d] = '1;
            end
            else if (level_en[d])
            begin
                res.vectors[d] = ns[d];
            end
            else
            begin
                res.vectors[d] = old_vectors[d];
            end
        end
    end

endmodule

@@ rtl/approx_bitparallel_matcher.sv @@
// Top level of the approximate bit-parallel (shift-or, k errors) matcher.
// Depends on abpm_pkg and abpm_step.
//
// Usage: load the 256-entry character table with action=1 transactions, set
// the masks and error limit over the APB-style port while idle, then stream
// text bytes with action=0. The block takes one transaction every cycle as
// long as results are taken; an accepted byte is held in the input stage until
// the stage advances and any result enters the output register. The character
// vector is read from the table through its registered read port when the
// byte is accepted; all error levels are then updated by a short chain of
// shifts and ANDs (one step per level), which is what closes the per-byte
// loop. A match gives found=1, the lowest error level that matched and the
// byte count since restart (saturating at 65535), and returns every level to
// all ones. Scan bytes without a match give no result. Table entries hold no
// reset value and need no clearing pass: reading one that was never loaded
// returns undefined data. When the output register is full and not taken,
// one further transaction is held in the input stage and input ready drops.
module approx_bitparallel_matcher (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [abpm_pkg::ADDR_W-1:0]  paddr,
    input  logic [abpm_pkg::REG_W-1:0]   pwdata,
    output logic [abpm_pkg::REG_W-1:0]   prdata,
    output logic                         pready,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic [abpm_pkg::CODE_W-1:0]  char_code,
    input  logic [abpm_pkg::REG_W-1:0]   table_vector,
    input  logic                         restart,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         found,
    output logic [abpm_pkg::LVL_W-1:0]   error_count,
    output logic [abpm_pkg::POS_W-1:0]   end_position
);
    import abpm_pkg::*;

    // configuration registers
    logic [2:0]        max_errors_reg;
    logic [REG_W-1:0]  match_mask_reg;
    logic [REG_W-1:0]  skip_mask_reg;
    logic [REG_W-1:0]  exact_mask_reg;
    logic              skip_enable_reg;
    logic              cfg_write;
    logic [2:0]        cfg_idx;

    // character table
    vec_t              char_table_mem [TABLE_DEPTH];

    // input stage
    logic              s1_valid_reg;
    logic              s1_action_reg;
    logic              s1_restart_reg;
    vec_t              tc_reg;
    logic              in_fire;
    logic              advance;

    // match state
    vecs_t             vectors_reg;
    logic [POS_W-1:0]  pos_reg;
    vecs_t             old_vectors;
    logic [POS_W-1:0]  pos_base;
    logic [POS_W-1:0]  pos_inc;
    step_cfg_t         step_cfg;
    step_res_t         step_res;
    logic              result_hit;

    // output register
    logic              out_valid_reg;
    logic              found_reg;
    logic [LVL_W-1:0]  error_count_reg;
    logic [POS_W-1:0]  end_position_reg;

    // ---------------------------------------------------------------
    // Configuration port: write in the access phase, read back as stored
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_errors_reg  <= '0;
            match_mask_reg  <= '1;
            skip_mask_reg   <= '1;
            exact_mask_reg  <= '0;
            skip_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_MAX_ERRORS:  max_errors_reg  <= pwdata[2:0];
                REG_MATCH_MASK:  match_mask_reg  <= pwdata;
                REG_SKIP_MASK:   skip_mask_reg   <= pwdata;
                REG_EXACT_MASK:  exact_mask_reg  <= pwdata;
                REG_SKIP_ENABLE: skip_enable_reg <= pwdata[0];
                default:         ; // unmapped: drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_ERRORS:  prdata = {{(REG_W-3){1'b0}}, max_errors_reg};
            REG_MATCH_MASK:  prdata = match_mask_reg;
            REG_SKIP_MASK:   prdata = skip_mask_reg;
            REG_EXACT_MASK:  prdata = exact_mask_reg;
            REG_SKIP_ENABLE: prdata = {{(REG_W-1){1'b0}}, skip_enable_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: the input stage advances whenever the output slot is
    // free or being emptied in the same cycle
    // ---------------------------------------------------------------
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Table write for loads and registered read for every transaction.
    // A load followed directly by a scan of the same code is seen, as
    // the scan's read comes at a later clock edge than the load's write.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (action)
            begin
                char_table_mem[char_code] <= to_vec(table_vector);
            end
            tc_reg         <= char_table_mem[char_code];
            s1_action_reg  <= action;
            s1_restart_reg <= restart;
        end
    end

    // ---------------------------------------------------------------
    // Level update: restart first, then the shift-or step
    // ---------------------------------------------------------------
    assign old_vectors = s1_restart_reg ? '1 : vectors_reg;
    assign pos_base    = s1_restart_reg ? '0 : pos_reg;
    assign pos_inc     = (pos_base == '1) ? pos_base : pos_base + 1'b1;

    assign step_cfg.skip_enable = skip_enable_reg;
    assign step_cfg.skip_mask   = to_vec(skip_mask_reg);
    assign step_cfg.exact_mask  = to_vec(exact_mask_reg);
    assign step_cfg.match_mask  = to_vec(match_mask_reg);
    assign step_cfg.max_errors  = max_errors_reg;

    abpm_step u_step (
        .old_vectors (old_vectors),
        .char_vector (tc_reg),
        .cfg         (step_cfg),
        .res         (step_res)
    );

    assign result_hit = !s1_action_reg && step_res.hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vectors_reg <= '1;
            pos_reg     <= '0;
        end
        else if (advance)
        begin
            if (s1_action_reg)
            begin
                // load: honour restart only, hold the position
                vectors_reg <= old_vectors;
                pos_reg     <= pos_base;
            end
            else
            begin
                vectors_reg <= step_res.vectors;
                pos_reg     <= pos_inc;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result_hit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result_hit)
        begin
            found_reg        <= step_res.hit;
            error_count_reg  <= step_res.level;
            end_position_reg <= pos_inc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign error_count  = error_count_reg;
    assign end_position = end_position_reg;

endmodule

@@ rtl/abpm_checker.sv @@
// Port-level checker for the approximate bit-parallel matcher, with its bind.
// Depends on abpm_pkg and approx_bitparallel_matcher_defines.svh.
`include "approx_bitparallel_matcher_defines.svh"

module abpm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        found,
    input logic [abpm_pkg::LVL_W-1:0]  error_count,
    input logic [abpm_pkg::POS_W-1:0]  end_position
);
    import abpm_pkg::*;

    // a result is only ever a match
    `ABPM_ASSERT(a_found_set, !out_valid || found, "result without found set")

    // reported level never exceeds the deepest level built
    `ABPM_ASSERT(a_level_range, !out_valid || (int'(error_count) <= MAX_ERR),
        "error count beyond highest level")

    // a match always counts at least its own byte
    `ABPM_ASSERT(a_pos_nonzero, !out_valid || (end_position != '0),
        "match reported at position zero")

    // stalled result holds
    `ABPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(error_count) && $stable(end_position),
        "stalled result changed")

endmodule

bind approx_bitparallel_matcher abpm_checker u_abpm_checker (.*);
